// ===== src/cmst_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell member set table package
// Field widths, opcodes and result status codes shared by the interfaces
// and the core.
// ----------------------------------------------------------------------------
package cmst_pkg;

   localparam int OPCODE_W     = 1;
   localparam int CELL_IDX_W   = 11;
   localparam int MEMBER_ID_W  = 32;
   localparam int STATUS_W     = 3;
   localparam int MEMBER_CNT_W = 4;

   // cell index widened far enough to compare against any table size below 2**17
   localparam int CELL_WIDE_W  = 17;

   localparam logic [OPCODE_W-1:0] OP_ADD    = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_IGNORED   = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

endpackage

// ===== src/cmst_chan_if.sv =====
// ----------------------------------------------------------------------------
// Cell member set table channels
// Valid/ready request and response channels of the table core.
// ----------------------------------------------------------------------------
interface cmst_req_if;
   import cmst_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [OPCODE_W-1:0]           opcode;
   logic signed [CELL_IDX_W-1:0]  cell_index;
   logic [MEMBER_ID_W-1:0]        member_id;

   modport source (output valid, output opcode, output cell_index, output member_id,
                   input ready);
   modport sink   (input valid, input opcode, input cell_index, input member_id,
                   output ready);
endinterface

interface cmst_rsp_if;
   import cmst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [MEMBER_CNT_W-1:0]  member_count;

   modport source (output valid, output status, output member_count, input ready);
   modport sink   (input valid, input status, input member_count, output ready);
endinterface

// ===== src/cmst_ram.sv =====
// ----------------------------------------------------------------------------
// Cell member set table RAM
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cmst_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cell_member_set_table_core.sv =====
// ----------------------------------------------------------------------------
// Cell member set table core
// Per-cell ordered id sets: add appends an absent id, remove deletes every
// copy of an id and compacts the remaining entries in order.
// ----------------------------------------------------------------------------
//   channel   direction  handshake     payload
//   req_chan  in         valid/ready   opcode, cell_index, member_id
//   rsp_chan  out        valid/ready   status, member_count
//
// A request makes one count RAM read, then the shared comparator walks the
// cell's slots one per cycle through the member RAM read port, then a
// write-back step. An add that hits ends the walk early, and an owner-id add
// skips the walk. Out-of-grid requests skip the count read and go straight
// to write-back. Requests are taken only when idle.
// After reset a clearing pass zeroes every entry of the count RAM, during
// which no request is taken. A waiting response holds the write-back cycle
// of the next request until it is taken.
// ----------------------------------------------------------------------------
module cell_member_set_table_core #(
   parameter int NUM_CELLS   = 1024,
   parameter int MAX_MEMBERS = 8
) (
   input logic     clock,
   input logic     reset,
   cmst_req_if.sink   req_chan,
   cmst_rsp_if.source rsp_chan
);
   import cmst_pkg::*;

   localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int SLOT_W    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int CNT_W     = $clog2(MAX_MEMBERS + 1);
   localparam int MEM_AW    = CELL_AW + SLOT_W;
   localparam int MEM_DEPTH = NUM_CELLS * (2 ** SLOT_W);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CNT_RD,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CELL_AW-1:0]        clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [MEMBER_CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [OPCODE_W-1:0]       op_ff, op_in;
   logic [CELL_AW-1:0]        cell_ff, cell_in;
   logic [MEMBER_ID_W-1:0]    id_ff, id_in;
   logic                      ign_ff, ign_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          iss_ff, iss_in;
   logic [CNT_W-1:0]          kept_ff, kept_in;
   logic                      cmp_valid_ff, cmp_valid_in;
   logic                      found_ff, found_in;

   logic                      mem_wr_en;
   logic [MEM_AW-1:0]         mem_wr_addr;
   logic [MEMBER_ID_W-1:0]    mem_wr_data;
   logic [MEM_AW-1:0]         mem_rd_addr;
   logic [MEMBER_ID_W-1:0]    mem_rd_data;

   logic                      cnt_wr_en;
   logic [CELL_AW-1:0]        cnt_wr_addr;
   logic [CNT_W-1:0]          cnt_wr_data;
   logic [CELL_AW-1:0]        cnt_rd_addr;
   logic [CNT_W-1:0]          cnt_rd_data;

   logic [CELL_WIDE_W-1:0]    req_cell_wide;
   logic                      req_cell_ok;
   logic                      req_take;
   logic                      cmp_hit;
   logic                      done_go;
   logic [CNT_W-1:0]          count_inc;
   logic [CNT_W+MEMBER_CNT_W-1:0] cnt_ext;
   logic [CNT_W-1:0]          rsp_cnt_full;

   assign req_cell_wide = {{(CELL_WIDE_W - CELL_IDX_W + 1){1'b0}},
                           req_chan.cell_index[CELL_IDX_W-2:0]};
   assign req_cell_ok   = !req_chan.cell_index[CELL_IDX_W-1] &&
                          (req_cell_wide < CELL_WIDE_W'(NUM_CELLS));
   assign req_take      = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign cmp_hit   = (mem_rd_data == id_ff);
   assign done_go   = !rsp_valid_ff || rsp_chan.ready;
   assign count_inc = count_ff + CNT_W'(1);
   assign cnt_rd_addr = req_cell_wide[CELL_AW-1:0];
   assign mem_rd_addr = {cell_ff, iss_ff[SLOT_W-1:0]};
   assign cnt_ext     = {{MEMBER_CNT_W{1'b0}}, rsp_cnt_full};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      op_in         = op_ff;
      cell_in       = cell_ff;
      id_in         = id_ff;
      ign_in        = ign_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      kept_in       = kept_ff;
      cmp_valid_in  = 1'b0;
      found_in      = found_ff;
      rsp_cnt_full  = count_ff;

      mem_wr_en     = 1'b0;
      mem_wr_addr   = {cell_ff, kept_ff[SLOT_W-1:0]};
      mem_wr_data   = mem_rd_data;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = cell_ff;
      cnt_wr_data   = count_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
            clr_in      = clr_ff + CELL_AW'(1);
            if (clr_ff == CELL_AW'(NUM_CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_chan.opcode;
               cell_in  = req_cell_wide[CELL_AW-1:0];
               id_in    = req_chan.member_id;
               found_in = 1'b0;
               count_in = '0;
               ign_in   = !req_cell_ok;
               state_in = req_cell_ok ? S_CNT_RD : S_DONE;
            end
         end
         S_CNT_RD: begin
            count_in = cnt_rd_data;
            iss_in   = '0;
            kept_in  = '0;
            // the owner id is never stored
            if (op_ff == OP_ADD && id_ff == '0) begin
               ign_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (iss_ff != count_ff) begin
               iss_in       = iss_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
            end
            if (cmp_valid_ff) begin
               if (op_ff == OP_ADD) begin
                  if (cmp_hit) begin
                     found_in = 1'b1;
                     state_in = S_DONE;
                  end
               end else if (!cmp_hit) begin
                  // keep the entry: move it down to the compacted position
                  mem_wr_en = 1'b1;
                  kept_in   = kept_ff + CNT_W'(1);
               end
            end
            if (iss_ff == count_ff && !cmp_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_go) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (ign_ff) begin
                  rsp_status_in = ST_IGNORED;
               end else if (op_ff == OP_ADD) begin
                  if (found_ff) begin
                     rsp_status_in = ST_PRESENT;
                  end else if (count_ff == CNT_W'(MAX_MEMBERS)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = {cell_ff, count_ff[SLOT_W-1:0]};
                     mem_wr_data   = id_ff;
                     cnt_wr_en     = 1'b1;
                     cnt_wr_data   = count_inc;
                     rsp_status_in = ST_ADDED;
                     rsp_cnt_full  = count_inc;
                  end
               end else if (kept_ff == count_ff) begin
                  rsp_status_in = ST_NOT_FOUND;
               end else begin
                  cnt_wr_en     = 1'b1;
                  cnt_wr_data   = kept_ff;
                  rsp_status_in = ST_REMOVED;
                  rsp_cnt_full  = kept_ff;
               end
               rsp_count_in = cnt_ext[MEMBER_CNT_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      op_ff         <= op_in;
      cell_ff       <= cell_in;
      id_ff         <= id_in;
      ign_ff        <= ign_in;
      count_ff      <= count_in;
      iss_ff        <= iss_in;
      kept_ff       <= kept_in;
      found_ff      <= found_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.member_count = rsp_count_ff;

   cmst_ram #(
      .WIDTH  (MEMBER_ID_W),
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (MEM_AW)
   ) u_member_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cmst_ram #(
      .WIDTH  (CNT_W),
      .DEPTH  (NUM_CELLS),
      .ADDR_W (CELL_AW)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> count_ff <= CNT_W'(MAX_MEMBERS))
      else $error("cell count above member limit during scan");

   a_kept_behind: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> kept_ff <= iss_ff)
      else $error("compaction write ahead of read pointer");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside write-back");

   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |=> !rsp_valid_ff)
      else $error("response during count clearing pass");

endmodule

// ===== sim/tb_cell_member_set_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cell member set table core testbench
// Drives add and remove requests over the request channel and predicts each
// response from a local copy of every cell's ordered id set. Directed tests
// cover out-of-grid cells, the owner id, full cells and compaction on remove;
// random traffic then works mostly a small pool of cells and ids, first under
// idling on both channels and then with none.
// ----------------------------------------------------------------------------
module tb_cell_member_set_table_core;
   import cmst_pkg::*;

   localparam int NUM_CELLS   = 1024;
   localparam int MAX_MEMBERS = 8;
   localparam int STALL_LIMIT = 4000;
   localparam logic signed [CELL_IDX_W-1:0] LAST_CELL = CELL_IDX_W'(NUM_CELLS - 1);

   typedef struct packed {
      status_type              status;
      logic [MEMBER_CNT_W-1:0] count;
   } table_result_type;

   logic clock;
   logic reset;

   cmst_req_if req_chan ();
   cmst_rsp_if rsp_chan ();

   cell_member_set_table_core #(
      .NUM_CELLS   (NUM_CELLS),
      .MAX_MEMBERS (MAX_MEMBERS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   logic [MEMBER_ID_W-1:0] cell_slots [NUM_CELLS][MAX_MEMBERS];
   int unsigned            cell_fill [NUM_CELLS];
   table_result_type       pending_results [$];
   int                     mismatch_count = 0;
   int                     stall_cycles   = 0;
   int                     send_idle_pct;
   int                     recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic table_result_type apply_table_request(
      input logic [OPCODE_W-1:0]          op,
      input logic signed [CELL_IDX_W-1:0] cell_idx,
      input logic [MEMBER_ID_W-1:0]       id
   );
      table_result_type res;
      int unsigned      idx;
      int unsigned      fill;
      int unsigned      kept;
      res.status = ST_IGNORED;
      res.count  = '0;
      if (cell_idx[CELL_IDX_W-1] || $unsigned(cell_idx) >= NUM_CELLS)
         return res;
      idx  = 32'($unsigned(cell_idx));
      fill = cell_fill[idx];
      if (fill > MAX_MEMBERS)
         fill = MAX_MEMBERS;
      res.count = MEMBER_CNT_W'(fill);
      if (op == OP_ADD) begin
         if (id == '0)
            return res;
         for (int i = 0; i < fill; i++) begin
            if (cell_slots[idx][i] == id) begin
               res.status = ST_PRESENT;
               return res;
            end
         end
         if (fill >= MAX_MEMBERS) begin
            res.status = ST_FULL;
            return res;
         end
         cell_slots[idx][fill] = id;
         cell_fill[idx]        = fill + 1;
         res.status            = ST_ADDED;
         res.count             = MEMBER_CNT_W'(fill + 1);
         return res;
      end
      // compact the surviving ids, keeping their order
      kept = 0;
      for (int i = 0; i < fill; i++) begin
         if (cell_slots[idx][i] != id) begin
            cell_slots[idx][kept] = cell_slots[idx][i];
            kept++;
         end
      end
      if (kept == fill) begin
         res.status = ST_NOT_FOUND;
         return res;
      end
      cell_fill[idx] = kept;
      res.status     = ST_REMOVED;
      res.count      = MEMBER_CNT_W'(kept);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // leaves valid high after acceptance; the next request's idle wait or the end drops it
   task automatic send_request(
      input logic [OPCODE_W-1:0]          op,
      input logic signed [CELL_IDX_W-1:0] cell_idx,
      input logic [MEMBER_ID_W-1:0]       id
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.cell_index <= cell_idx;
      req_chan.member_id  <= id;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      pending_results.push_back(apply_table_request(op, cell_idx, id));
   endtask

   task automatic test_out_of_grid();
      send_request(OP_ADD, CELL_IDX_W'(-1), 32'd5);
      send_request(OP_REMOVE, CELL_IDX_W'(-1024), 32'hFFFF_FFFF);
   endtask

   task automatic test_owner_id();
      send_request(OP_ADD, '0, 32'd0);
      send_request(OP_REMOVE, '0, 32'd0);
   endtask

   task automatic test_fill_and_full();
      send_request(OP_ADD, LAST_CELL, 32'hFFFF_FFFF);
      for (int i = 1; i < MAX_MEMBERS; i++)
         send_request(OP_ADD, LAST_CELL, MEMBER_ID_W'(i));
      send_request(OP_ADD, LAST_CELL, 32'd9);
      // present wins over full
      send_request(OP_ADD, LAST_CELL, 32'd1);
   endtask

   task automatic test_remove_compaction();
      send_request(OP_REMOVE, LAST_CELL, 32'd3);
      send_request(OP_REMOVE, LAST_CELL, 32'd3);
      send_request(OP_REMOVE, LAST_CELL, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, LAST_CELL, MEMBER_ID_W'(MAX_MEMBERS - 1));
      send_request(OP_ADD, LAST_CELL, 32'd3);
      send_request(OP_REMOVE, LAST_CELL, 32'd4);
   endtask

   // most traffic hits a few cells with a few ids so sets fill, hit and empty
   task automatic test_random_traffic(input int n_items);
      logic signed [CELL_IDX_W-1:0] pool_cells [6];
      logic [MEMBER_ID_W-1:0]       pool_ids [12];
      logic [OPCODE_W-1:0]          op;
      logic signed [CELL_IDX_W-1:0] cell_idx;
      logic [MEMBER_ID_W-1:0]       id;
      int                           pick;
      pool_cells[0] = '0;
      pool_cells[1] = LAST_CELL;
      for (int i = 2; i < 6; i++)
         pool_cells[i] = CELL_IDX_W'($urandom_range(NUM_CELLS - 1));
      for (int i = 0; i < 12; i++)
         pool_ids[i] = (i < 6) ? MEMBER_ID_W'(i + 1) : $urandom_range(32'hFFFF_FFFF, 1);
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            op       = ($urandom_range(99) < 58) ? OP_ADD : OP_REMOVE;
            cell_idx = pool_cells[$urandom_range(5)];
            id       = ($urandom_range(99) < 2) ? '0 : pool_ids[$urandom_range(11)];
         end else if (pick < 90) begin
            op       = OPCODE_W'($urandom_range(1));
            cell_idx = CELL_IDX_W'($urandom_range(2047));
            id       = $urandom();
         end else begin
            op       = OPCODE_W'($urandom_range(1));
            cell_idx = CELL_IDX_W'($urandom_range(NUM_CELLS - 1));
            id       = $urandom();
         end
         send_request(op, cell_idx, id);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      table_result_type want;
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response status %0d count %0d",
                                      rsp_chan.status, rsp_chan.member_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch($sformatf("status %0d, want %s", rsp_chan.status,
                                         want.status.name()));
            if (rsp_chan.member_count !== want.count)
               report_mismatch($sformatf("member_count %0d, want %0d",
                                         rsp_chan.member_count, want.count));
         end
      end
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_ADD;
      req_chan.cell_index = '0;
      req_chan.member_id  = '0;
      send_idle_pct       = 37;
      recv_idle_pct       = 65;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_out_of_grid();
      test_owner_id();
      test_fill_and_full();
      test_remove_compaction();
      test_random_traffic(610);
      send_idle_pct = 65;
      recv_idle_pct = 37;
      test_random_traffic(610);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(610);

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== cell_member_set_table_core.f =====
src/cmst_pkg.sv
src/cmst_chan_if.sv
src/cmst_ram.sv
src/cell_member_set_table_core.sv
sim/tb_cell_member_set_table_core.sv
